FILE: rtl/atomic_memory_op_emulation_macros.svh
// Assertion macros for the atomic memory op emulation block.
// Empty bodies when SYNTHESIS is defined; no other dependencies.
`ifndef ATOMIC_MEMORY_OP_EMULATION_MACROS_SVH
`define ATOMIC_MEMORY_OP_EMULATION_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AMOEMU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amoemu same-cycle check failed");
// next-cycle implication
`define AMOEMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amoemu next-cycle check failed");
`else
`define AMOEMU_ASSERT_NOW(label, clk, rst, ante, cons)
`define AMOEMU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/amoemu_pkg.sv
// Shared types and constants for the atomic memory op emulation block.
// No dependencies.
package amoemu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned REG_AW   = 5;
  localparam int unsigned REG_NUM  = 32;

  // major opcode of the A extension
  localparam logic [6:0] OPC_AMO = 7'h2F;

  // operation code, instruction bits 31..27
  typedef enum logic [4:0] {
    AMO_ADD  = 5'h00,
    AMO_SWAP = 5'h01,
    AMO_LR   = 5'h02,
    AMO_SC   = 5'h03,
    AMO_XOR  = 5'h04,
    AMO_OR   = 5'h08,
    AMO_AND  = 5'h0C,
    AMO_MIN  = 5'h10,
    AMO_MAX  = 5'h14,
    AMO_MINU = 5'h18,
    AMO_MAXU = 5'h1C
  } amo_op_t;

  // decoded item held in the input register
  typedef struct packed {
    logic              handled;
    amo_op_t           op;
    logic [XLEN-1:0]   mem_word;
    logic [REG_AW-1:0] rd;
  } amoemu_item_t;

  // one result item
  typedef struct packed {
    logic              handled;
    logic [XLEN-1:0]   mem_address;
    logic              store_enable;
    logic [XLEN-1:0]   store_data;
    logic [REG_AW-1:0] dest_index;
    logic [XLEN-1:0]   dest_value;
  } amoemu_result_t;

  // true for the operation codes this block executes
  function automatic logic op_known(input logic [4:0] f);
    logic k;
    unique case (f)
      AMO_ADD, AMO_SWAP, AMO_LR, AMO_SC, AMO_XOR, AMO_OR, AMO_AND,
      AMO_MIN, AMO_MAX, AMO_MINU, AMO_MAXU: k = 1'b1;
      default:                               k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/atomic_memory_op_emulation.sv
// Atomic memory op emulation, top level. An input transfer passes the input register
// (with the register file read) and then the result register on its way to the result.
// Throughput: one transfer per cycle while m_tready does not stall the output; decode
// and ALU are combinational. Reset clears the pipeline valid flags and the register file
// valid bits at once; no clearing pass, an input transfer can be taken right out of reset.
// Depends on amoemu_pkg, amoemu_regfile, amoemu_alu and the macros header.
`include "atomic_memory_op_emulation_macros.svh"

module atomic_memory_op_emulation (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // instruction_word[31:0], memory_word[63:32], reg_index[68:64], reg_value[100:69]
  input  logic [103:0] s_tdata,
  // kind[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // mem_address[31:0], store_enable[32], store_data[64:33], dest_index[69:65],
  // dest_value[101:70]
  output logic [103:0] m_tdata,
  // handled[0]
  output logic         m_tuser
);

  logic                              accept;
  logic                              advance;
  logic [amoemu_pkg::XLEN-1:0]       insn;
  logic [amoemu_pkg::XLEN-1:0]       mem_word;
  logic [amoemu_pkg::REG_AW-1:0]     reg_index;
  logic [amoemu_pkg::XLEN-1:0]       reg_value;
  logic                              exec_ok;
  amoemu_pkg::amoemu_item_t          item_next;
  logic                              wr_en;
  logic [amoemu_pkg::REG_AW-1:0]     wr_addr;
  logic [amoemu_pkg::XLEN-1:0]       wr_data;
  logic                              s1_valid;
  amoemu_pkg::amoemu_item_t          s1_item;
  logic [amoemu_pkg::XLEN-1:0]       rs1_val;
  logic [amoemu_pkg::XLEN-1:0]       rs2_val;
  amoemu_pkg::amoemu_result_t        alu_res;
  amoemu_pkg::amoemu_result_t        out_res;

  // input field split
  assign insn      = s_tdata[31:0];
  assign mem_word  = s_tdata[63:32];
  assign reg_index = s_tdata[68:64];
  assign reg_value = s_tdata[100:69];

  // handshake
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // decode: supported opcode and operation
  assign exec_ok = s_tuser && (insn[6:0] == amoemu_pkg::OPC_AMO)
                   && amoemu_pkg::op_known(insn[31:27]);

  always_comb begin
    item_next.handled  = exec_ok;
    item_next.op       = exec_ok ? amoemu_pkg::amo_op_t'(insn[31:27]) : amoemu_pkg::AMO_ADD;
    item_next.mem_word = mem_word;
    item_next.rd       = insn[11:7];
  end

  // destination write does not depend on sources, so it happens at transfer
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = insn[11:7];
    wr_data = mem_word;
    if (accept) begin
      if (!s_tuser) begin
        wr_en   = 1'b1;
        wr_addr = reg_index;
        wr_data = reg_value;
      end else if (exec_ok) begin
        wr_en = 1'b1;
        if (insn[31:27] == amoemu_pkg::AMO_SC) begin
          wr_data = '0;
        end
      end
    end
  end

  amoemu_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (accept),
    .rd_addr_a (insn[19:15]),
    .rd_addr_b (insn[24:20]),
    .rd_data_a (rs1_val),
    .rd_data_b (rs2_val)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item_next;
    end
  end

  amoemu_alu u_alu (
    .item    (s1_item),
    .rs1_val (rs1_val),
    .rs2_val (rs2_val),
    .res     (alu_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_res <= alu_res;
    end
  end

  assign m_tuser = out_res.handled;
  assign m_tdata = {2'b00, out_res.dest_value, out_res.dest_index, out_res.store_data,
                    out_res.store_enable, out_res.mem_address};

  // checks
  `AMOEMU_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)
  `AMOEMU_ASSERT_NOW(a_store_needs_handled, clk, rst, m_tvalid && m_tdata[32], m_tuser)
  `AMOEMU_ASSERT_NOW(a_unhandled_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  `AMOEMU_ASSERT_NEXT(a_other_opcode_unhandled, clk, rst,
    accept && s_tuser && (s_tdata[6:0] != amoemu_pkg::OPC_AMO), !s1_item.handled)

endmodule

FILE: rtl/amoemu_regfile.sv
// Register file: 32 x 32 memory, one write port, two registered read ports.
// Per-entry valid bits give the all-zero reset; entry 0 is never written.
// Depends on amoemu_pkg.
module amoemu_regfile (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [amoemu_pkg::REG_AW-1:0]  wr_addr,
  input  logic [amoemu_pkg::XLEN-1:0]    wr_data,
  input  logic                           rd_en,
  input  logic [amoemu_pkg::REG_AW-1:0]  rd_addr_a,
  input  logic [amoemu_pkg::REG_AW-1:0]  rd_addr_b,
  output logic [amoemu_pkg::XLEN-1:0]    rd_data_a,
  output logic [amoemu_pkg::XLEN-1:0]    rd_data_b
);

  logic [amoemu_pkg::XLEN-1:0]    mem [amoemu_pkg::REG_NUM];
  logic [amoemu_pkg::REG_NUM-1:0] valid;
  logic [amoemu_pkg::XLEN-1:0]    data_a;
  logic [amoemu_pkg::XLEN-1:0]    data_b;
  logic                           valid_a;
  logic                           valid_b;
  logic                           wr_ok;

  assign wr_ok = wr_en && (wr_addr != '0);

  // storage write; read data sees the old contents on a same-edge write
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_a <= mem[rd_addr_a];
      data_b <= mem[rd_addr_b];
    end
  end

  // valid bits and their registered copies
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_a <= valid[rd_addr_a];
        valid_b <= valid[rd_addr_b];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data_a = valid_a ? data_a : '0;
  assign rd_data_b = valid_b ? data_b : '0;

endmodule

FILE: rtl/amoemu_alu.sv
// Result logic: store value, destination value and zeroing of unhandled items.
// Depends on amoemu_pkg.
module amoemu_alu (
  input  amoemu_pkg::amoemu_item_t    item,
  input  logic [amoemu_pkg::XLEN-1:0] rs1_val,
  input  logic [amoemu_pkg::XLEN-1:0] rs2_val,
  output amoemu_pkg::amoemu_result_t  res
);

  logic [amoemu_pkg::XLEN-1:0] mem;
  logic [amoemu_pkg::XLEN-1:0] sum;
  logic                        lt_s;
  logic                        lt_u;
  logic [amoemu_pkg::XLEN-1:0] new_val;
  logic [amoemu_pkg::XLEN-1:0] rd_val;
  logic                        st;

  assign mem  = item.mem_word;
  assign sum  = mem + rs2_val;
  assign lt_s = $signed(mem) < $signed(rs2_val);
  assign lt_u = mem < rs2_val;

  // operation select
  always_comb begin
    new_val = '0;
    rd_val  = mem;
    st      = 1'b1;
    unique case (item.op)
      amoemu_pkg::AMO_LR:   st = 1'b0;
      amoemu_pkg::AMO_SC: begin
        new_val = rs2_val;
        rd_val  = '0;
      end
      amoemu_pkg::AMO_ADD:  new_val = sum;
      amoemu_pkg::AMO_SWAP: new_val = rs2_val;
      amoemu_pkg::AMO_XOR:  new_val = mem ^ rs2_val;
      amoemu_pkg::AMO_AND:  new_val = mem & rs2_val;
      amoemu_pkg::AMO_OR:   new_val = mem | rs2_val;
      amoemu_pkg::AMO_MIN:  new_val = lt_s ? mem : rs2_val;
      amoemu_pkg::AMO_MAX:  new_val = lt_s ? rs2_val : mem;
      amoemu_pkg::AMO_MINU: new_val = lt_u ? mem : rs2_val;
      amoemu_pkg::AMO_MAXU: new_val = lt_u ? rs2_val : mem;
      default:              st = 1'b0;
    endcase
  end

  // all fields zero unless the item was executed
  always_comb begin
    res = '0;
    if (item.handled) begin
      res.handled      = 1'b1;
      res.mem_address  = rs1_val;
      res.store_enable = st;
      res.store_data   = new_val;
      res.dest_index   = item.rd;
      res.dest_value   = rd_val;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for atomic_memory_op_emulation: register loads and
// RV32A atomic instructions go in, results are predicted and compared per field.
// Depends on amoemu_pkg and the atomic_memory_op_emulation RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned XW          = amoemu_pkg::XLEN;
  localparam int unsigned RUN_LIMIT   = 1_000_000;
  localparam int unsigned RAND_ITEMS  = 1900;
  localparam int unsigned HOLD_AT     = 500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_AT    = 1000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam logic        KIND_LOAD   = 1'b0;
  localparam logic        KIND_EXEC   = 1'b1;

  // one pending input transfer; drain holds it back until all results are in
  typedef struct {
    logic                          kind;
    logic [XW-1:0]                 insn;
    logic [XW-1:0]                 mem;
    logic [amoemu_pkg::REG_AW-1:0] ridx;
    logic [XW-1:0]                 rval;
    bit                            drain;
  } stim_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tuser;

  stim_item_t                 stim_q[$];
  amoemu_pkg::amoemu_result_t pending_results[$];
  logic [XW-1:0]              arch_regs[amoemu_pkg::REG_NUM];

  int unsigned total_items = 0;
  int unsigned in_count = 0;
  int unsigned out_count = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left = 0;
  int unsigned rdy_stall = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  amoemu_pkg::amo_op_t known_ops[11] = '{
    amoemu_pkg::AMO_ADD, amoemu_pkg::AMO_SWAP, amoemu_pkg::AMO_LR, amoemu_pkg::AMO_SC,
    amoemu_pkg::AMO_XOR, amoemu_pkg::AMO_OR, amoemu_pkg::AMO_AND, amoemu_pkg::AMO_MIN,
    amoemu_pkg::AMO_MAX, amoemu_pkg::AMO_MINU, amoemu_pkg::AMO_MAXU};

  atomic_memory_op_emulation dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  function automatic logic [XW-1:0] amo_insn(input logic [4:0] op, input logic [1:0] aqrl,
                                             input logic [4:0] rs2, input logic [4:0] rs1,
                                             input logic [2:0] f3, input logic [4:0] rd);
    return {op, aqrl, rs2, rs1, f3, rd, amoemu_pkg::OPC_AMO};
  endfunction

  // biased toward the corner values of a 32-bit word
  function automatic logic [XW-1:0] pick_word();
    logic [XW-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = 32'hFFFF_FFFF;
      2:       w = 32'h8000_0000;
      3:       w = 32'h7FFF_FFFF;
      4:       w = $urandom_range(0, 3);
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // most gaps short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r, g;
    r = $urandom_range(0, 99);
    if (r < 60)      g = 0;
    else if (r < 92) g = $urandom_range(1, 3);
    else             g = $urandom_range(8, 40);
    return g;
  endfunction

  function automatic bit op_listed(input logic [4:0] f);
    bit k;
    case (f)
      amoemu_pkg::AMO_ADD, amoemu_pkg::AMO_SWAP, amoemu_pkg::AMO_LR, amoemu_pkg::AMO_SC,
      amoemu_pkg::AMO_XOR, amoemu_pkg::AMO_OR, amoemu_pkg::AMO_AND, amoemu_pkg::AMO_MIN,
      amoemu_pkg::AMO_MAX, amoemu_pkg::AMO_MINU, amoemu_pkg::AMO_MAXU: k = 1'b1;
      default:                                                        k = 1'b0;
    endcase
    return k;
  endfunction

  function automatic void add_load(input logic [4:0] idx, input logic [XW-1:0] val);
    stim_item_t it;
    it.kind  = KIND_LOAD;
    it.insn  = $urandom();
    it.mem   = $urandom();
    it.ridx  = idx;
    it.rval  = val;
    it.drain = 1'b0;
    stim_q.push_back(it);
  endfunction

  function automatic void add_exec(input logic [XW-1:0] insn, input logic [XW-1:0] mem);
    stim_item_t it;
    it.kind  = KIND_EXEC;
    it.insn  = insn;
    it.mem   = mem;
    it.ridx  = 5'($urandom());
    it.rval  = $urandom();
    it.drain = 1'b0;
    stim_q.push_back(it);
  endfunction

  // Register model read with x0 hardwired to zero
  function automatic logic [XW-1:0] reg_read(input logic [4:0] idx);
    return (idx == '0) ? '0 : arch_regs[idx];
  endfunction

  // Expected result of one input transfer; updates the register model
  function automatic amoemu_pkg::amoemu_result_t amo_predict(input logic kind,
                                                             input logic [XW-1:0] insn,
                                                             input logic [XW-1:0] mem,
                                                             input logic [4:0] ridx,
                                                             input logic [XW-1:0] rval);
    amoemu_pkg::amoemu_result_t res;
    logic [XW-1:0]              rs1v, rs2v, newv, rdv;
    logic [4:0]                 rd;
    logic                       st, ok;
    res = '0;
    if (kind == KIND_LOAD) begin
      if (ridx != '0) arch_regs[ridx] = rval;
      return res;
    end
    if (insn[6:0] != amoemu_pkg::OPC_AMO) return res;
    // sources are read before rd is written
    rs1v = reg_read(insn[19:15]);
    rs2v = reg_read(insn[24:20]);
    rd   = insn[11:7];
    newv = '0;
    rdv  = mem;
    st   = 1'b1;
    ok   = 1'b1;
    case (insn[31:27])
      amoemu_pkg::AMO_LR:   st = 1'b0;
      amoemu_pkg::AMO_SC: begin
        newv = rs2v;
        rdv  = '0;
      end
      amoemu_pkg::AMO_ADD:  newv = mem + rs2v;
      amoemu_pkg::AMO_SWAP: newv = rs2v;
      amoemu_pkg::AMO_XOR:  newv = mem ^ rs2v;
      amoemu_pkg::AMO_AND:  newv = mem & rs2v;
      amoemu_pkg::AMO_OR:   newv = mem | rs2v;
      amoemu_pkg::AMO_MIN:  newv = ($signed(mem) < $signed(rs2v)) ? mem : rs2v;
      amoemu_pkg::AMO_MAX:  newv = ($signed(mem) < $signed(rs2v)) ? rs2v : mem;
      amoemu_pkg::AMO_MINU: newv = (mem < rs2v) ? mem : rs2v;
      amoemu_pkg::AMO_MAXU: newv = (mem < rs2v) ? rs2v : mem;
      default:              ok = 1'b0;
    endcase
    if (!ok) return res;
    if (rd != '0) arch_regs[rd] = rdv;
    res.handled      = 1'b1;
    res.mem_address  = rs1v;
    res.store_enable = st;
    res.store_data   = newv;
    res.dest_index   = rd;
    res.dest_value   = rdv;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [XW-1:0] want,
                                      input logic [XW-1:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch on result %0d, %s: expected %h, got %h",
                 out_count, name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    stim_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      gap_left <= 0;
    end else if (s_tvalid && !s_tready) begin
      // transfer pending, hold everything
    end else if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (stim_q.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (stim_q[0].drain && (s_tvalid || in_count != out_count)) begin
      // pause until every result of earlier items has come out
      s_tvalid <= 1'b0;
    end else begin
      it = stim_q.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= {3'b000, it.rval, it.ridx, it.mem, it.insn};
      s_tuser  <= it.kind;
      // stretches with back-to-back transfers
      gap_left <= ((in_count / 150) % 4 == 1) ? 0 : pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    int unsigned g;
    if (rst) begin
      m_tready  <= 1'b0;
      rdy_stall <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && out_count >= HOLD_AT) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (rdy_stall > 0) begin
      m_tready  <= 1'b0;
      rdy_stall <= rdy_stall - 1;
    end else if ((cycle_count / 500) % 3 == 0) begin
      m_tready <= 1'b1;
    end else begin
      g = pick_gap();
      if (g == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready  <= 1'b0;
        rdy_stall <= g - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input transfers, checks output transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    amoemu_pkg::amoemu_result_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_results.push_back(amo_predict(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                              s_tdata[68:64], s_tdata[100:69]));
        in_count <= in_count + 1;
      end
      if (m_tvalid && m_tready) begin
        got.handled      = m_tuser;
        got.mem_address  = m_tdata[31:0];
        got.store_enable = m_tdata[32];
        got.store_data   = m_tdata[64:33];
        got.dest_index   = m_tdata[69:65];
        got.dest_value   = m_tdata[101:70];
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %0d: handled %b, tdata %h", out_count, m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("handled", XW'(want.handled), XW'(got.handled));
          check_field("mem_address", want.mem_address, got.mem_address);
          check_field("store_enable", XW'(want.store_enable), XW'(got.store_enable));
          check_field("store_data", want.store_data, got.store_data);
          check_field("dest_index", XW'(want.dest_index), XW'(got.dest_index));
          check_field("dest_value", want.dest_value, got.dest_value);
        end
        out_count <= out_count + 1;
      end
    end
  end

  // Run limit
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** atomic_memory_op_emulation: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [4:0]    op;
    logic [XW-1:0] insn;
    int unsigned   r;

    foreach (arch_regs[i]) arch_regs[i] = '0;

    // directed: extreme register values, x0 write ignored
    add_load(5'd0, 32'hDEAD_BEEF);
    add_load(5'd1, 32'hFFFF_FFFF);
    add_load(5'd2, 32'h8000_0000);
    add_load(5'd3, 32'h7FFF_FFFF);
    add_load(5'd31, 32'h0000_0001);
    // every operation, aq/rl and funct3 set to odd values
    add_exec(amo_insn(amoemu_pkg::AMO_LR,   2'b11, 5'd9, 5'd1,  3'd7, 5'd4),  32'h1234_5678);
    add_exec(amo_insn(amoemu_pkg::AMO_SC,   2'b01, 5'd2, 5'd31, 3'd2, 5'd5),  32'hFFFF_FFFF);
    add_exec(amo_insn(amoemu_pkg::AMO_ADD,  2'b10, 5'd1, 5'd2,  3'd2, 5'd6),  32'hFFFF_FFFF);
    add_exec(amo_insn(amoemu_pkg::AMO_SWAP, 2'b00, 5'd3, 5'd3,  3'd0, 5'd7),  32'h0000_0000);
    add_exec(amo_insn(amoemu_pkg::AMO_XOR,  2'b00, 5'd1, 5'd4,  3'd2, 5'd8),  32'hAAAA_5555);
    add_exec(amo_insn(amoemu_pkg::AMO_AND,  2'b11, 5'd3, 5'd5,  3'd2, 5'd9),  32'hFFFF_FFFF);
    add_exec(amo_insn(amoemu_pkg::AMO_OR,   2'b00, 5'd2, 5'd6,  3'd2, 5'd10), 32'h0000_0000);
    add_exec(amo_insn(amoemu_pkg::AMO_MIN,  2'b00, 5'd2, 5'd1,  3'd2, 5'd11), 32'h7FFF_FFFF);
    add_exec(amo_insn(amoemu_pkg::AMO_MAX,  2'b01, 5'd3, 5'd1,  3'd2, 5'd12), 32'h8000_0000);
    add_exec(amo_insn(amoemu_pkg::AMO_MINU, 2'b00, 5'd2, 5'd2,  3'd2, 5'd13), 32'h7FFF_FFFF);
    add_exec(amo_insn(amoemu_pkg::AMO_MAXU, 2'b10, 5'd1, 5'd3,  3'd2, 5'd14), 32'h0000_0000);
    // destination zero, x0 as both sources
    add_exec(amo_insn(amoemu_pkg::AMO_ADD,  2'b00, 5'd0, 5'd0,  3'd2, 5'd0),  32'h0000_0005);
    // rs1 == rs2 == rd: sources read before the write
    add_exec(amo_insn(amoemu_pkg::AMO_ADD,  2'b00, 5'd1, 5'd1,  3'd2, 5'd1),  32'h0000_0003);
    add_exec(amo_insn(amoemu_pkg::AMO_LR,   2'b00, 5'd0, 5'd31, 3'd2, 5'd31), 32'hFFFF_FFFF);
    // other major opcode and unknown operation codes
    add_exec({amoemu_pkg::AMO_SWAP, 2'b00, 5'd1, 5'd2, 3'd2, 5'd3, 7'h33}, 32'hFFFF_FFFF);
    add_exec(amo_insn(5'h05, 2'b00, 5'd1,  5'd2,  3'd2, 5'd3),  32'hFFFF_FFFF);
    add_exec(amo_insn(5'h1F, 2'b11, 5'd31, 5'd31, 3'd7, 5'd31), 32'hFFFF_FFFF);
    // load of zero into register 20; its instruction field is random
    add_load(5'd20, 32'h0000_0000);

    // random: mostly well-formed atomics on a register file kept busy by loads
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        add_load(5'($urandom()), pick_word());
      end else if (r < 85) begin
        op = known_ops[$urandom_range(0, 10)];
        add_exec(amo_insn(op, 2'($urandom()), 5'($urandom()), 5'($urandom()),
                          3'($urandom()), 5'($urandom())), pick_word());
      end else if (r < 92) begin
        op = 5'($urandom());
        while (op_listed(op)) op = 5'($urandom());
        add_exec(amo_insn(op, 2'($urandom()), 5'($urandom()), 5'($urandom()),
                          3'($urandom()), 5'($urandom())), pick_word());
      end else begin
        insn = $urandom();
        if (insn[6:0] == amoemu_pkg::OPC_AMO) insn[0] = ~insn[0];
        add_exec(insn, pick_word());
      end
    end
    stim_q[DRAIN_AT].drain = 1'b1;
    total_items = stim_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all items in, all results out
    while (in_count != total_items || out_count != in_count) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("** atomic_memory_op_emulation: PASSED **");
    else
      $display("** atomic_memory_op_emulation: FAILED **");
    $finish;
  end

endmodule
